### hdl/rrtn_pkg.sv
// Shared types and constants for the sampling-tree node store.
package rrtn_pkg;

	localparam int COORD_W   = 20;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int SQ_W      = 2 * DIFF_W;
	localparam int DIST_W    = SQ_W;
	localparam int DSQ_OUT_W = 41;
	localparam int IDX_OUT_W = 9;
	localparam int RAD_W     = 16;
	localparam int R2_W      = 2 * RAD_W;

	typedef enum logic [1:0] {
		FN_RESTART = 2'd0,
		FN_NEAREST = 2'd1,
		FN_APPEND  = 2'd2,
		FN_TRACE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_FULL       = 2'd2,
		ST_BAD_PARENT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_GOAL_X      = 2'd0,
		CFG_GOAL_Y      = 2'd1,
		CFG_GOAL_RADIUS = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DRAIN,
		S_TRACE_RD
	} fsm_t;

	typedef struct packed {
		logic                      valid;
		logic                      is_goal;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} dist_tag_t;

endpackage

### hdl/rrtn_ram.sv
// Generic single-port RAM with registered read.
module rrtn_ram
	#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
	) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### hdl/rrtn_dist.sv
// Three-stage squared-distance chain: difference, square, sum.
module rrtn_dist
	import rrtn_pkg::*;
	#(
	parameter int IW = 9
	) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dist_tag_t                 in_tag,
	input  logic [IW-1:0]             in_idx,
	input  logic signed [COORD_W-1:0] ax,
	input  logic signed [COORD_W-1:0] ay,
	input  logic signed [COORD_W-1:0] bx,
	input  logic signed [COORD_W-1:0] by,
	output dist_tag_t                 out_tag,
	output logic [IW-1:0]             out_idx,
	output logic [DIST_W-1:0]         out_sum,
	output logic                      busy
	);

	dist_tag_t                tag_s1, tag_s2, tag_s3;
	logic [IW-1:0]            idx_s1, idx_s2, idx_s3;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic signed [SQ_W-1:0]   sx_s2, sy_s2;
	logic [DIST_W-1:0]        sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= in_idx;
		dx_s1  <= DIFF_W'(ax) - DIFF_W'(bx);
		dy_s1  <= DIFF_W'(ay) - DIFF_W'(by);
		idx_s2 <= idx_s1;
		sx_s2  <= dx_s1 * dx_s1;
		sy_s2  <= dy_s1 * dy_s1;
		idx_s3 <= idx_s2;
		sum_s3 <= DIST_W'(unsigned'(sx_s2)) + DIST_W'(unsigned'(sy_s2));
	end

	assign out_tag = tag_s3;
	assign out_idx = idx_s3;
	assign out_sum = sum_s3;
	assign busy    = tag_s1.valid | tag_s2.valid | tag_s3.valid;

endmodule

### hdl/rrt_tree_nearest_node_store_top.sv
// Top level of the sampling-tree node store with nearest-node search.
// One request is handled at a time. During a nearest query the node
// RAM is read once per cycle and each node streams through the
// three-stage distance chain, which also handles the goal-circle test.
// No clearing pass is needed.
module rrt_tree_nearest_node_store_top
	import rrtn_pkg::*;
	#(
	parameter int MAX_NODES = 512
	) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [1:0]                func,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic [IDX_OUT_W-1:0]      parent_index,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic [IDX_OUT_W-1:0]      node_index,
	output logic signed [COORD_W-1:0] node_x,
	output logic signed [COORD_W-1:0] node_y,
	output logic [DSQ_OUT_W-1:0]      dist_sq,
	output logic                      in_goal,
	output logic                      at_root,
	output logic [1:0]                status,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [COORD_W-1:0]        cfg_data
	);

	localparam int AW  = $clog2(MAX_NODES);
	localparam int CW  = $clog2(MAX_NODES + 1);
	localparam int PCW = (CW > IDX_OUT_W) ? CW : IDX_OUT_W;
	localparam int DW  = AW + 2 * COORD_W;

	fsm_t state_q, state_d;

	logic signed [COORD_W-1:0] goal_x_q, goal_y_q;
	logic [RAD_W-1:0]          goal_radius_q;
	logic [R2_W-1:0]           r2_q;

	func_t                     func_q;
	logic signed [COORD_W-1:0] px_q, py_q;
	logic [IDX_OUT_W-1:0]      parent_q;

	logic [CW-1:0]  count_q;
	logic [AW-1:0]  count_m1;
	logic [AW-1:0]  cursor_q, cursor_start;
	logic           trace_active_q;
	logic [AW-1:0]  scan_q;
	logic           rd_valid_s1;
	logic [AW-1:0]  rd_idx_s1;
	logic           first_q;
	logic           rsp_valid_q;

	logic [DIST_W-1:0] best_q;
	logic [AW-1:0]     best_idx_q;
	logic signed [COORD_W-1:0] best_x_q, best_y_q;

	logic [IDX_OUT_W-1:0]      o_idx_q;
	logic signed [COORD_W-1:0] o_x_q, o_y_q;
	logic [DSQ_OUT_W-1:0]      o_dsq_q;
	logic                      o_goal_q, o_root_q;
	status_t                   o_status_q;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [DW-1:0] ram_wdata, ram_rdata;
	logic signed [COORD_W-1:0] ram_x, ram_y;
	logic [AW-1:0] ram_parent;

	dist_tag_t                 pipe_tag_in, pipe_tag_out;
	logic [AW-1:0]             pipe_idx_in, pipe_idx_out;
	logic signed [COORD_W-1:0] pipe_bx, pipe_by;
	logic [DIST_W-1:0]         pipe_sum;
	logic                      pipe_busy;

	logic req_fire, rsp_fire;
	logic is_empty, is_full, bad_parent, drained;

	assign req_ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign req_fire  = req_valid && req_ready;
	assign rsp_fire  = rsp_valid_q && rsp_ready;

	assign count_m1     = AW'(count_q - CW'(1));
	assign cursor_start = trace_active_q ? cursor_q : count_m1;
	assign is_empty     = (count_q == '0);
	assign is_full      = (count_q == CW'(MAX_NODES));
	assign bad_parent   = (PCW'(parent_q) >= PCW'(count_q));
	assign drained      = !pipe_busy && !rd_valid_s1;

	assign ram_x      = ram_rdata[COORD_W-1:0];
	assign ram_y      = ram_rdata[2*COORD_W-1:COORD_W];
	assign ram_parent = ram_rdata[DW-1:2*COORD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q      <= '0;
			goal_y_q      <= '0;
			goal_radius_q <= RAD_W'(300);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GOAL_X:      goal_x_q      <= cfg_data;
				CFG_GOAL_Y:      goal_y_q      <= cfg_data;
				CFG_GOAL_RADIUS: goal_radius_q <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		r2_q <= goal_radius_q * goal_radius_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ram_we      = 1'b0;
		ram_addr    = scan_q;
		ram_wdata   = {AW'(parent_q), py_q, px_q};
		pipe_tag_in = '{valid: rd_valid_s1, is_goal: 1'b0, x: ram_x, y: ram_y};
		pipe_idx_in = rd_idx_s1;
		pipe_bx     = ram_x;
		pipe_by     = ram_y;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				pipe_tag_in = '{valid: 1'b1, is_goal: 1'b1, x: px_q, y: py_q};
				pipe_bx     = goal_x_q;
				pipe_by     = goal_y_q;
				unique case (func_q)
					FN_RESTART: begin
						ram_we    = 1'b1;
						ram_addr  = '0;
						ram_wdata = {{AW{1'b0}}, py_q, px_q};
						state_d   = S_DRAIN;
					end
					FN_NEAREST: begin
						if (is_empty) begin
							pipe_tag_in.valid = 1'b0;
							state_d           = S_IDLE;
						end else begin
							state_d = S_SCAN;
						end
					end
					FN_APPEND: begin
						if (is_empty) begin
							pipe_tag_in.valid = 1'b0;
							state_d           = S_IDLE;
						end else begin
							ram_we   = !is_full && !bad_parent;
							ram_addr = count_q[AW-1:0];
							state_d  = S_DRAIN;
						end
					end
					FN_TRACE: begin
						pipe_tag_in.valid = 1'b0;
						ram_addr          = cursor_start;
						state_d           = is_empty ? S_IDLE : S_TRACE_RD;
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				if (scan_q == count_m1) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (drained) begin
					state_d = S_IDLE;
				end
			end
			S_TRACE_RD: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	rrtn_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_NODES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	rrtn_dist #(
		.IW(AW)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.in_tag (pipe_tag_in),
		.in_idx (pipe_idx_in),
		.ax     (px_q),
		.ay     (py_q),
		.bx     (pipe_bx),
		.by     (pipe_by),
		.out_tag(pipe_tag_out),
		.out_idx(pipe_idx_out),
		.out_sum(pipe_sum),
		.busy   (pipe_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			cursor_q       <= '0;
			trace_active_q <= 1'b0;
			scan_q         <= '0;
			rd_valid_s1    <= 1'b0;
			first_q        <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_SCAN);
			if (rsp_fire) begin
				rsp_valid_q <= 1'b0;
			end
			if (pipe_tag_out.valid && !pipe_tag_out.is_goal) begin
				first_q <= 1'b0;
			end
			unique case (state_q)
				S_EXEC: begin
					scan_q  <= '0;
					first_q <= 1'b1;
					unique case (func_q)
						FN_RESTART: begin
							count_q        <= CW'(1);
							cursor_q       <= '0;
							trace_active_q <= 1'b0;
						end
						FN_APPEND: begin
							if (!is_empty && !is_full && !bad_parent) begin
								count_q        <= count_q + CW'(1);
								trace_active_q <= 1'b0;
							end
						end
						FN_TRACE: begin
							cursor_q       <= cursor_start;
							trace_active_q <= !is_empty;
						end
						default: ;
					endcase
					if (is_empty && func_q != FN_RESTART) begin
						rsp_valid_q <= 1'b1;
					end
				end
				S_SCAN: begin
					scan_q <= scan_q + AW'(1);
				end
				S_DRAIN: begin
					if (drained) begin
						rsp_valid_q <= 1'b1;
					end
				end
				S_TRACE_RD: begin
					if (cursor_q == '0) begin
						trace_active_q <= 1'b0;
					end else begin
						cursor_q <= ram_parent;
					end
					rsp_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q;
		if (req_fire) begin
			func_q   <= func_t'(func);
			px_q     <= point_x;
			py_q     <= point_y;
			parent_q <= parent_index;
		end
		if (pipe_tag_out.valid) begin
			if (pipe_tag_out.is_goal) begin
				o_goal_q <= (pipe_sum <= DIST_W'(r2_q));
			end else if (first_q || pipe_sum < best_q) begin
				best_q     <= pipe_sum;
				best_idx_q <= pipe_idx_out;
				best_x_q   <= pipe_tag_out.x;
				best_y_q   <= pipe_tag_out.y;
			end
		end
		unique case (state_q)
			S_EXEC: begin
				o_dsq_q  <= '0;
				o_goal_q <= 1'b0;
				o_root_q <= 1'b0;
				if (is_empty && func_q != FN_RESTART) begin
					o_idx_q    <= '0;
					o_x_q      <= '0;
					o_y_q      <= '0;
					o_status_q <= ST_EMPTY;
				end else if (func_q == FN_RESTART) begin
					o_idx_q    <= '0;
					o_x_q      <= px_q;
					o_y_q      <= py_q;
					o_status_q <= ST_OK;
				end else if (func_q == FN_APPEND && !is_full && !bad_parent) begin
					o_idx_q    <= IDX_OUT_W'(count_q);
					o_x_q      <= px_q;
					o_y_q      <= py_q;
					o_status_q <= ST_OK;
				end else begin
					o_idx_q <= '0;
					o_x_q   <= '0;
					o_y_q   <= '0;
					if (func_q != FN_APPEND) begin
						o_status_q <= ST_OK;
					end else if (is_full) begin
						o_status_q <= ST_FULL;
					end else begin
						o_status_q <= ST_BAD_PARENT;
					end
				end
			end
			S_DRAIN: begin
				if (drained && func_q == FN_NEAREST) begin
					o_idx_q <= IDX_OUT_W'(best_idx_q);
					o_x_q   <= best_x_q;
					o_y_q   <= best_y_q;
					o_dsq_q <= best_q[DSQ_OUT_W-1:0];
				end
			end
			S_TRACE_RD: begin
				o_idx_q  <= IDX_OUT_W'(cursor_q);
				o_x_q    <= ram_x;
				o_y_q    <= ram_y;
				o_root_q <= (cursor_q == '0);
			end
			default: ;
		endcase
	end

	assign rsp_valid  = rsp_valid_q;
	assign node_index = o_idx_q;
	assign node_x     = o_x_q;
	assign node_y     = o_y_q;
	assign dist_sq    = o_dsq_q;
	assign in_goal    = o_goal_q;
	assign at_root    = o_root_q;
	assign status     = o_status_q;

endmodule
